// File: src/fadm_pkg.sv
// Shared types, constants and register codes for the filtered arcade drive mixer.
package fadm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = SAMPLE_BITS - 1;
  localparam int WINDOW_BITS    = 5;
  localparam int DEADBAND_BITS  = FRAC_BITS;
  localparam int CFG_DATA_BITS  = (WINDOW_BITS > DEADBAND_BITS) ? WINDOW_BITS : DEADBAND_BITS;
  localparam int CFG_IDX_BITS   = 1;
  localparam int DEPTH_DEF      = 32;
  localparam int COUNT_BITS_DEF = $clog2(DEPTH_DEF + 1);
  localparam int TOTAL_BITS_DEF = SAMPLE_BITS + COUNT_BITS_DEF;

  localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET   = WINDOW_BITS'(25);
  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = DEADBAND_BITS'(1311);

  // edge counter codes
  localparam logic [1:0] TOG_SET  = 2'd0;
  localparam logic [1:0] TOG_CLR  = 2'd2;
  localparam logic [1:0] SEL_RAW  = 2'd0;
  localparam logic [1:0] SEL_MEAN = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW,
    CFG_DEADBAND
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SQ_GO,
    ST_SQ,
    ST_MIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] throttle_sample;
    logic signed [SAMPLE_BITS-1:0] turn_sample;
    logic                          solenoid_button;
    logic                          mode_button;
    logic                          enabled;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_drive;
    logic signed [SAMPLE_BITS-1:0] right_drive;
    logic                          solenoid_on;
    logic                          drive_valid;
  } out_item_t;

endpackage

// File: src/fadm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module fadm_div
  import fadm_pkg::*;
#(
  parameter int NUM_W = TOTAL_BITS_DEF,
  parameter int DEN_W = COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_BITS = $clog2(NUM_W + 1);

  logic                run_q;
  logic                done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_BITS'(NUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// File: src/fadm_sq.sv
// Bit-serial squarer of a magnitude, with round-half-up rescale to Q1.15.
module fadm_sq
  import fadm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] mag_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] res_o
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);
  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic                   run_q;
  logic                   rnd_q;
  logic                   done_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [SAMPLE_BITS-1:0] hi_q;
  logic [SAMPLE_BITS-1:0] lo_q;
  logic [SAMPLE_BITS-1:0] mc_q;
  logic [SAMPLE_BITS-1:0] res_q;
  logic [SAMPLE_BITS:0]   psum;
  logic [PROD_W-1:0]      rsum;

  always_comb begin
    psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
    rsum = {hi_q, lo_q} + HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      rnd_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_BITS'(SAMPLE_BITS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end else if (rnd_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q <= mag_i;
      lo_q <= mag_i;
      hi_q <= '0;
    end else if (run_q) begin
      hi_q <= psum[SAMPLE_BITS:1];
      lo_q <= {psum[0], lo_q[SAMPLE_BITS-1:1]};
    end
    if (rnd_q) begin
      res_q <= rsum[FRAC_BITS +: SAMPLE_BITS];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: src/filtered_arcade_drive_mixer.sv
// Top level: button edge logic, throttle history and mean, squaring and drive mixing.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------
//   input    | in_valid_i / in_stall_o  | in_item_i
//   output   | out_valid_o / out_stall_i| out_item_o
//   config   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One item at a time. An enabled item runs through the two bit-serial squarers; with the
// averaged throttle the one-bit-per-cycle serial divider runs first, one quotient bit per dividend bit.
// Reset clears counters and history fill and restores default settings; history words
// are only read once written.
// The next item can be accepted the cycle after the result loads, even while that result waits on a stall.
module filtered_arcade_drive_mixer
  import fadm_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W  = SAMPLE_BITS + CNT_W;
  localparam int CMP_W  = (CNT_W > WINDOW_BITS) ? CNT_W : WINDOW_BITS;
  localparam int OW     = CNT_W + 1;
  localparam int MW     = SAMPLE_BITS + 2;
  localparam logic signed [MW-1:0] FS_M  = MW'((1 << FRAC_BITS) - 1);
  localparam logic signed [MW-1:0] NFS_M = -FS_M;
  localparam logic [FRAC_BITS-1:0] FS_MAG = FRAC_BITS'((1 << FRAC_BITS) - 1);

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_fn(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] r;
    r = v;
    if (v > FS_M) r = FS_M;
    else if (v < NFS_M) r = NFS_M;
    return $signed(r[SAMPLE_BITS-1:0]);
  endfunction

  state_e state_q, state_d;

  logic [WINDOW_BITS-1:0]   window_q;
  logic [DEADBAND_BITS-1:0] deadband_q;

  logic [CNT_W-1:0]        fill_q;
  logic [ADDR_W-1:0]       wslot_q;
  logic signed [TOT_W-1:0] total_q;
  logic [1:0]              tog_cnt_q, sel_cnt_q;
  logic                    tog_prev_q, sel_prev_q, valve_q;
  logic                    ev_q, mean_q, out_valid_q;

  logic [CNT_W-1:0]       n_q;
  logic [FRAC_BITS-1:0]   am_q;
  logic                   a_neg_q;
  logic [SAMPLE_BITS-1:0] pm_q;
  logic                   p_neg_q;
  logic signed [MW-1:0]   left_q, right_q;
  logic                   dv_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  out_item_t              out_q;

  logic [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];

  logic in_acc, out_free, div_start, sq_start, out_load;

  // accept-time terms
  logic                   tog_chg, sel_chg;
  logic [1:0]             tog_cnt_n, sel_cnt_n;
  logic                   valve_n;
  logic [SAMPLE_BITS-1:0] turn_u, turn_abs, smp_u, smp_abs;
  logic                   turn_min;
  logic [FRAC_BITS-1:0]   ang_mag;
  logic [CMP_W-1:0]       win_ext, win_lim, win_eff;
  logic [CNT_W-1:0]       n_n;
  logic                   ev_n;
  logic [ADDR_W-1:0]      wslot_n;

  logic [OW-1:0]          ws_e, n_e, old_full;
  logic [ADDR_W-1:0]      old_addr;
  logic [TOT_W-1:0]       tot_abs;

  logic                   div_done;
  logic [TOT_W-1:0]       div_quo;
  logic                   sq_p_done, sq_a_done;
  logic [SAMPLE_BITS-1:0] sq_p_res, sq_a_res;

  logic signed [MW-1:0]   tv, av, nav, sum_ta, dif_ta, mix_l, mix_r;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // accept-time decode
  always_comb begin
    tog_chg   = in_item_i.solenoid_button != tog_prev_q;
    sel_chg   = in_item_i.mode_button != sel_prev_q;
    tog_cnt_n = tog_cnt_q + {1'b0, tog_chg};
    sel_cnt_n = sel_cnt_q + {1'b0, sel_chg};
    if (tog_cnt_n == TOG_SET) valve_n = 1'b1;
    else if (tog_cnt_n == TOG_CLR) valve_n = 1'b0;
    else valve_n = valve_q;

    turn_u   = in_item_i.turn_sample;
    turn_abs = turn_u[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - turn_u) : turn_u;
    turn_min = turn_u == {1'b1, {FRAC_BITS{1'b0}}};
    ang_mag  = turn_min ? FS_MAG : turn_abs[FRAC_BITS-1:0];

    smp_u   = in_item_i.throttle_sample;
    smp_abs = smp_u[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - smp_u) : smp_u;

    win_ext = CMP_W'(window_q);
    win_lim = CMP_W'(HISTORY_DEPTH - 1);
    win_eff = (win_ext > win_lim) ? win_lim : win_ext;
    n_n     = fill_q + CNT_W'(1);
    ev_n    = CMP_W'(n_n) > win_eff;
    wslot_n = (wslot_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + ADDR_W'(1);

    ws_e     = OW'(wslot_q);
    n_e      = OW'(n_q);
    old_full = (ws_e >= n_e) ? (ws_e - n_e) : (ws_e + OW'(HISTORY_DEPTH) - n_e);
    old_addr = old_full[ADDR_W-1:0];

    tot_abs = total_q[TOT_W-1] ? (TOT_W'(0) - TOT_W'(total_q)) : TOT_W'(total_q);
  end

  // mixing of signed squares
  always_comb begin
    tv     = $signed({2'b00, sq_p_res});
    av     = $signed({2'b00, sq_a_res});
    if (p_neg_q) tv = -tv;
    if (a_neg_q) av = -av;
    nav    = -av;
    sum_ta = tv + av;
    dif_ta = tv - av;
    if (sq_a_res == '0) begin
      mix_l = tv;
      mix_r = tv;
    end else if (tv > 0) begin
      if (av < 0) begin
        mix_l = av;
        mix_r = dif_ta;
      end else begin
        mix_l = sum_ta;
        mix_r = nav;
      end
    end else begin
      if (av > 0) begin
        mix_l = (tv > nav) ? tv : nav;
        mix_r = sum_ta;
      end else begin
        mix_l = dif_ta;
        mix_r = (tv > av) ? tv : av;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = in_item_i.enabled ? ST_PREP : ST_OUT;
      end
      ST_PREP:  state_d = ST_DIV;
      ST_DIV: begin
        if (!mean_q || div_done) state_d = ST_SQ_GO;
      end
      ST_SQ_GO: state_d = ST_SQ;
      ST_SQ: begin
        if (sq_p_done) state_d = ST_MIX;
      end
      ST_MIX:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_PREP:  div_start  = mean_q;
      ST_SQ_GO: sq_start   = 1'b1;
      ST_OUT:   out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      deadband_q  <= DEADBAND_RESET;
      fill_q      <= '0;
      wslot_q     <= '0;
      total_q     <= '0;
      tog_cnt_q   <= '0;
      sel_cnt_q   <= '0;
      tog_prev_q  <= 1'b0;
      sel_prev_q  <= 1'b0;
      valve_q     <= 1'b0;
      ev_q        <= 1'b0;
      mean_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW:   window_q   <= cfg_data_i[WINDOW_BITS-1:0];
          CFG_DEADBAND: deadband_q <= cfg_data_i[DEADBAND_BITS-1:0];
        endcase
      end

      if (in_acc) begin
        if (in_item_i.enabled) begin
          tog_cnt_q  <= tog_cnt_n;
          sel_cnt_q  <= sel_cnt_n;
          tog_prev_q <= in_item_i.solenoid_button;
          sel_prev_q <= in_item_i.mode_button;
          valve_q    <= valve_n;
          wslot_q    <= wslot_n;
          total_q    <= total_q + TOT_W'(in_item_i.throttle_sample);
          fill_q     <= ev_n ? (n_n - CNT_W'(1)) : n_n;
          ev_q       <= ev_n;
          mean_q     <= sel_cnt_n == SEL_MEAN;
        end else begin
          fill_q  <= '0;
          wslot_q <= '0;
          total_q <= '0;
          ev_q    <= 1'b0;
          mean_q  <= 1'b0;
        end
      end else if (state_q == ST_DIV && ev_q) begin
        // drop the oldest sample; in mean mode the divider already holds the full sum
        total_q <= total_q - TOT_W'($signed(rd_q));
        ev_q    <= 1'b0;
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.enabled) begin
      hist_mem[wslot_q] <= in_item_i.throttle_sample;
    end
    if (state_q == ST_PREP) begin
      rd_q <= hist_mem[old_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q     <= n_n;
      am_q    <= (ang_mag >= deadband_q) ? ang_mag : '0;
      a_neg_q <= !turn_u[SAMPLE_BITS-1];
      dv_q    <= in_item_i.enabled;
      left_q  <= '0;
      right_q <= '0;
      if (sel_cnt_n == SEL_RAW) begin
        pm_q    <= smp_abs;
        p_neg_q <= smp_u[SAMPLE_BITS-1];
      end else begin
        pm_q    <= '0;
        p_neg_q <= 1'b0;
      end
    end
    if (state_q == ST_PREP && mean_q) begin
      p_neg_q <= total_q[TOT_W-1];
    end
    if (state_q == ST_DIV && mean_q && div_done) begin
      pm_q <= div_quo[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_MIX) begin
      left_q  <= mix_l;
      right_q <= mix_r;
    end
    if (out_load) begin
      out_q.left_drive  <= clamp_fn(left_q);
      out_q.right_drive <= clamp_fn(-right_q);
      out_q.solenoid_on <= valve_q;
      out_q.drive_valid <= dv_q;
    end
  end

  fadm_div #(
    .NUM_W (TOT_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tot_abs),
    .den_i   (n_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  fadm_sq u_sq_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .mag_i   (pm_q),
    .done_o  (sq_p_done),
    .res_o   (sq_p_res)
  );

  fadm_sq u_sq_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .mag_i   ({1'b0, am_q}),
    .done_o  (sq_a_done),
    .res_o   (sq_a_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_sq_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_p_done == sq_a_done)
    else $error("squarers out of step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("item accepted while previous item in progress");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(HISTORY_DEPTH - 1))
    else $error("history fill beyond ring");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule

// File: verif/filtered_arcade_drive_mixer_tb.sv
// Self-checking testbench for filtered_arcade_drive_mixer: directed plan, random phases, predictor.
module filtered_arcade_drive_mixer_tb;
  import fadm_pkg::*;

  localparam int          DEPTH       = DEPTH_DEF;
  localparam longint      FULL        = (64'sd1 <<< FRAC_BITS) - 1;
  localparam int          AXIS_MAX    = (1 << FRAC_BITS) - 1;
  localparam int          AXIS_MIN    = -(1 << FRAC_BITS);
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_ITEMS = 55;
  localparam int          NUM_PHASES  = 7;
  localparam int          PH_WIN  [6] = '{0, 31, 2, 1, 31, 5};
  localparam int          PH_BAND [6] = '{0, 32767, 150, 1311, 0, 2000};

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // throttle    turn          sol   mode  en    typed left    right   sol   valid
    {16'sd0,       16'sd0,       1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 1'b0, 1'b0},
    {16'sd0,       16'sd0,       1'b0, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1, 1'b1},
    {16'sh7FFF,    16'sd0,       1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sh8000,    16'sd0,       1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd0,       16'sh8000,    1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd0,       16'sh7FFF,    1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd20000,   16'sd1000,    1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd20000,   16'sd1311,    1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd20000,   -16'sd20000,  1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd20000,   16'sd20000,   1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {-16'sd20000,  -16'sd20000,  1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {-16'sd20000,  16'sd20000,   1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd10000,   16'sd5000,    1'b1, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd10000,   16'sd5000,    1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd10000,   -16'sd5000,   1'b1, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd10000,   -16'sd5000,   1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd30000,   16'sd3000,    1'b0, 1'b1, 1'b1, 1'b0, 34'd0},
    {-16'sd30000,  16'sd0,       1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd12345,   -16'sd4000,   1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd0,       16'sd0,       1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0, 1'b1, 1'b0},
    {-16'sd7,      16'sd0,       1'b0, 1'b0, 1'b1, 1'b0, 34'd0},
    {16'sd25000,   16'sd9000,    1'b0, 1'b1, 1'b1, 1'b0, 34'd0},
    {-16'sd25000,  -16'sd9000,   1'b0, 1'b0, 1'b1, 1'b0, 34'd0}
  };

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  in_item_t                 in_item_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_item_t                out_item_o;
  logic                     cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  filtered_arcade_drive_mixer #(
    .HISTORY_DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  longint      hist_q [DEPTH];
  int unsigned fill_q  = 0;
  int unsigned slot_q  = 0;
  longint      total_q = 0;
  logic [1:0]  tog_cnt = '0;
  logic [1:0]  sel_cnt = '0;
  logic        tog_prev = 1'b0;
  logic        sel_prev = 1'b0;
  logic        valve    = 1'b0;
  int unsigned win_reg  = WINDOW_RESET;
  int unsigned band_reg = DEADBAND_RESET;

  out_item_t   pending_drive [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_left  = 0;
  logic        sol_lvl    = 1'b0;
  logic        mode_lvl   = 1'b0;
  bit          no_gaps    = 1'b0;
  out_item_t   got_drive;
  out_item_t   want_drive;

  function automatic longint square_keep_sign(longint v);
    longint m;
    longint s;
    m = (v < 0) ? -v : v;
    s = (m * m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (v < 0) ? -s : s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_drive(longint v);
    if (v > FULL) v = FULL;
    if (v < -FULL) v = -FULL;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic out_item_t mix_drive(in_item_t it);
    out_item_t   r;
    longint      samp;
    longint      ang;
    longint      pwr;
    longint      a;
    longint      t;
    longint      lft;
    longint      rgt;
    int unsigned win;
    int unsigned cnt;
    int unsigned oldest;
    r = '0;
    if (!it.enabled) begin
      fill_q  = 0;
      slot_q  = 0;
      total_q = 0;
      r.solenoid_on = valve;
      return r;
    end
    if (it.solenoid_button != tog_prev) tog_cnt = tog_cnt + 2'd1;
    tog_prev = it.solenoid_button;
    if (tog_cnt == TOG_SET) valve = 1'b1;
    else if (tog_cnt == TOG_CLR) valve = 1'b0;
    if (it.mode_button != sel_prev) sel_cnt = sel_cnt + 2'd1;
    sel_prev = it.mode_button;

    win = (win_reg > DEPTH - 1) ? DEPTH - 1 : win_reg;
    samp = longint'(it.throttle_sample);
    hist_q[slot_q] = samp;
    slot_q = (slot_q + 1) % DEPTH;
    total_q += samp;
    cnt = fill_q + 1;

    pwr = 0;
    if (sel_cnt == SEL_RAW) pwr = samp;
    else if (sel_cnt == SEL_MEAN) pwr = total_q / longint'(cnt);

    ang = -longint'(it.turn_sample);
    if (ang > FULL) ang = FULL;
    if (((ang < 0) ? -ang : ang) < longint'(band_reg)) ang = 0;

    a = square_keep_sign(ang);
    t = square_keep_sign(pwr);
    if (t > 0) begin
      if (a < 0) begin
        rgt = t - a;
        lft = (t < a) ? t : a;
      end else begin
        rgt = (t < -a) ? t : -a;
        lft = t + a;
      end
    end else begin
      if (a > 0) begin
        lft = -((-t < a) ? -t : a);
        rgt = t + a;
      end else begin
        lft = t - a;
        rgt = -((-t < -a) ? -t : -a);
      end
    end
    // zero turn after squaring: straight drive
    if (a == 0) begin
      lft = t;
      rgt = t;
    end

    if (cnt > win) begin
      oldest = (slot_q + DEPTH - cnt) % DEPTH;
      total_q -= hist_q[oldest];
      cnt--;
    end
    fill_q = cnt;

    r.left_drive  = clamp_drive(lft);
    r.right_drive = clamp_drive(-rgt);
    r.solenoid_on = valve;
    r.drive_valid = 1'b1;
    return r;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_axis();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 4))
        0:       return SAMPLE_BITS'(AXIS_MIN);
        1:       return SAMPLE_BITS'(AXIS_MAX);
        2:       return '0;
        3:       return '1;
        default: return SAMPLE_BITS'(1);
      endcase
    end
    if (r < 4) return SAMPLE_BITS'(int'($urandom_range(0, 800)) - 400);
    return SAMPLE_BITS'($urandom());
  endfunction

  function automatic in_item_t next_tick();
    in_item_t it;
    if ($urandom_range(0, 3) == 0) sol_lvl = ~sol_lvl;
    if ($urandom_range(0, 9) == 0) mode_lvl = ~mode_lvl;
    it.throttle_sample = pick_axis();
    it.turn_sample     = pick_axis();
    it.solenoid_button = sol_lvl;
    it.mode_button     = mode_lvl;
    it.enabled         = ($urandom_range(0, 11) != 0);
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic push_tick(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t guess;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    guess = mix_drive(it);
    pending_drive.push_back(typed ? want : guess);
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = no_gaps ? 0 : pause_len();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_knobs(input int unsigned win, input int unsigned band);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW;
    cfg_data_i <= CFG_DATA_BITS'(win);
    @(posedge clk_i);
    win_reg    = win & ((1 << WINDOW_BITS) - 1);
    cfg_idx_i  <= CFG_DEADBAND;
    cfg_data_i <= CFG_DATA_BITS'(band);
    @(posedge clk_i);
    band_reg   = band & ((1 << DEADBAND_BITS) - 1);
    cfg_we_i   <= 1'b0;
  endtask

  // receiver: random stall and free stretches
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      hold_left   <= pause_len();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_drive = out_item_o;
      if (pending_drive.size() == 0) begin
        flag_mismatch("unexpected item, left_drive", got_drive.left_drive, 0);
      end else begin
        want_drive = pending_drive.pop_front();
        if (got_drive.left_drive !== want_drive.left_drive)
          flag_mismatch("left_drive", got_drive.left_drive, want_drive.left_drive);
        if (got_drive.right_drive !== want_drive.right_drive)
          flag_mismatch("right_drive", got_drive.right_drive, want_drive.right_drive);
        if (got_drive.solenoid_on !== want_drive.solenoid_on)
          flag_mismatch("solenoid_on", got_drive.solenoid_on, want_drive.solenoid_on);
        if (got_drive.drive_valid !== want_drive.drive_valid)
          flag_mismatch("drive_valid", got_drive.drive_valid, want_drive.drive_valid);
      end
    end
  end

  initial begin
    int unsigned win;
    int unsigned band;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (i > 0) idle_gap();
      push_tick(PLAN[i].stim, PLAN[i].typed, PLAN[i].want);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      win  = (p < 6) ? PH_WIN[p]  : $urandom_range(0, 31);
      band = (p < 6) ? PH_BAND[p] : $urandom_range(0, 32767);
      set_knobs(win, band);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i > 0) idle_gap();
        push_tick(next_tick(), 1'b0, '0);
      end
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
